[src/srct_pkg.sv]
// Shared widths and types for the segment / rectangle contact test.
`timescale 1ns / 1ps
`default_nettype none

package srct_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int MAG_W      = COORD_BITS;
  localparam int PROD_W     = 2 * DIFF_W;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic        [MAG_W-1:0]      mag_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

endpackage

`default_nettype wire

[src/srct_ifs.sv]
// Request and result channel interfaces of the segment / rectangle contact test.
`timescale 1ns / 1ps
`default_nettype none

interface srct_req_if;
  import srct_pkg::*;

  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  coord_t rect_left;
  coord_t rect_right;
  coord_t rect_bottom;
  coord_t rect_top;

  modport source (
    output valid, start_x, start_y, end_x, end_y,
           rect_left, rect_right, rect_bottom, rect_top,
    input  ready
  );

  modport sink (
    input  valid, start_x, start_y, end_x, end_y,
           rect_left, rect_right, rect_bottom, rect_top,
    output ready
  );
endinterface

interface srct_res_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

`default_nettype wire

[src/segment_rect_clip_test.sv]
// Segment against axis-aligned rectangle contact test, four-stage pipeline.
//
// Takes one request per clock and returns one hit bit per request, in order.
// An accepted request passes through the four registers in order: stage one
// forms the coordinate differences and the endpoint-inside tests, stage two
// picks the entry and exit numerators per axis and the direction magnitudes,
// stage three holds the four signed 17x17 cross products that compare the
// crossing parameters exactly, and the output register holds the decision.
// Each stage has its own valid bit and fills any empty slot, so the sustained
// rate is one request per cycle, reduced only by back-pressure on the result
// channel. The hit test is exact: an endpoint inside the closed rectangle
// hits; otherwise the entry interval of the clipped parameter must be
// non-empty.
`timescale 1ns / 1ps
`default_nettype none

module segment_rect_clip_test (
  input  wire        clk,
  input  wire        rst_n,
  srct_req_if.sink   in_ch,
  srct_res_if.source out_ch
);
  import srct_pkg::*;

  typedef struct packed {
    diff_t dx;
    diff_t dy;
    diff_t lx;
    diff_t xr;
    diff_t rx;
    diff_t xl;
    diff_t by;
    diff_t yt;
    diff_t ty;
    diff_t yb;
    logic  pt_in;
    logic  rl_ok;
    logic  tb_ok;
  } st1_t;

  typedef struct packed {
    diff_t nxe;
    diff_t nxx;
    diff_t nye;
    diff_t nyx;
    mag_t  ax;
    mag_t  ay;
    logic  zx;
    logic  zy;
    logic  par_x;
    logic  par_y;
    logic  rl_ok;
    logic  tb_ok;
    logic  pt_in;
  } st2_t;

  typedef struct packed {
    prod_t pa;
    prod_t pb;
    prod_t pc;
    prod_t pd;
    logic  okx;
    logic  oky;
    logic  zx;
    logic  zy;
    logic  pt_in;
  } st3_t;

  st1_t s1_r, s1_nxt;
  st2_t s2_r, s2_nxt;
  st3_t s3_r, s3_nxt;
  logic s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;
  logic out_hit_r, out_hit_nxt;
  logic s1_rdy, s2_rdy, s3_rdy, out_rdy;

  assign out_rdy = !out_vld_r || out_ch.ready;
  assign s3_rdy  = !s3_vld_r || out_rdy;
  assign s2_rdy  = !s2_vld_r || s3_rdy;
  assign s1_rdy  = !s1_vld_r || s2_rdy;

  assign in_ch.ready  = s1_rdy;
  assign out_ch.valid = out_vld_r;
  assign out_ch.hit   = out_hit_r;

  // Stage one: differences and endpoint containment
  always_comb begin
    diff_t x0, y0, x1, y1, l, r, b, t;
    logic  in0, in1;
    x0 = diff_t'(in_ch.start_x);
    y0 = diff_t'(in_ch.start_y);
    x1 = diff_t'(in_ch.end_x);
    y1 = diff_t'(in_ch.end_y);
    l  = diff_t'(in_ch.rect_left);
    r  = diff_t'(in_ch.rect_right);
    b  = diff_t'(in_ch.rect_bottom);
    t  = diff_t'(in_ch.rect_top);
    in0 = (in_ch.start_x >= in_ch.rect_left) && (in_ch.start_x <= in_ch.rect_right) &&
          (in_ch.start_y >= in_ch.rect_bottom) && (in_ch.start_y <= in_ch.rect_top);
    in1 = (in_ch.end_x >= in_ch.rect_left) && (in_ch.end_x <= in_ch.rect_right) &&
          (in_ch.end_y >= in_ch.rect_bottom) && (in_ch.end_y <= in_ch.rect_top);
    s1_nxt.dx    = x1 - x0;
    s1_nxt.dy    = y1 - y0;
    s1_nxt.lx    = l - x0;
    s1_nxt.xr    = x0 - r;
    s1_nxt.rx    = r - x0;
    s1_nxt.xl    = x0 - l;
    s1_nxt.by    = b - y0;
    s1_nxt.yt    = y0 - t;
    s1_nxt.ty    = t - y0;
    s1_nxt.yb    = y0 - b;
    s1_nxt.pt_in = in0 || in1;
    s1_nxt.rl_ok = in_ch.rect_right >= in_ch.rect_left;
    s1_nxt.tb_ok = in_ch.rect_top >= in_ch.rect_bottom;
  end

  // Stage two: entry and exit numerators over a positive per-axis denominator
  always_comb begin
    logic   px, py;
    diff_t  ndx, ndy;
    px  = !s1_r.dx[DIFF_W-1];
    py  = !s1_r.dy[DIFF_W-1];
    ndx = -s1_r.dx;
    ndy = -s1_r.dy;
    s2_nxt.nxe   = px ? s1_r.lx : s1_r.xr;
    s2_nxt.nxx   = px ? s1_r.rx : s1_r.xl;
    s2_nxt.nye   = py ? s1_r.by : s1_r.yt;
    s2_nxt.nyx   = py ? s1_r.ty : s1_r.yb;
    s2_nxt.ax    = px ? mag_t'(s1_r.dx) : mag_t'(ndx);
    s2_nxt.ay    = py ? mag_t'(s1_r.dy) : mag_t'(ndy);
    s2_nxt.zx    = s1_r.dx == '0;
    s2_nxt.zy    = s1_r.dy == '0;
    s2_nxt.par_x = !s1_r.xl[DIFF_W-1] && !s1_r.rx[DIFF_W-1];
    s2_nxt.par_y = !s1_r.yb[DIFF_W-1] && !s1_r.ty[DIFF_W-1];
    s2_nxt.rl_ok = s1_r.rl_ok;
    s2_nxt.tb_ok = s1_r.tb_ok;
    s2_nxt.pt_in = s1_r.pt_in;
  end

  // Stage three: cross products and per-axis interval checks
  always_comb begin
    diff_t sax, say;
    sax = diff_t'({1'b0, s2_r.ax});
    say = diff_t'({1'b0, s2_r.ay});
    s3_nxt.pa    = prod_t'(s2_r.nxe) * prod_t'(say);
    s3_nxt.pb    = prod_t'(s2_r.nyx) * prod_t'(sax);
    s3_nxt.pc    = prod_t'(s2_r.nye) * prod_t'(sax);
    s3_nxt.pd    = prod_t'(s2_r.nxx) * prod_t'(say);
    s3_nxt.okx   = s2_r.zx ? s2_r.par_x
                 : (!s2_r.nxx[DIFF_W-1] && (s2_r.nxe <= sax) && s2_r.rl_ok);
    s3_nxt.oky   = s2_r.zy ? s2_r.par_y
                 : (!s2_r.nyx[DIFF_W-1] && (s2_r.nye <= say) && s2_r.tb_ok);
    s3_nxt.zx    = s2_r.zx;
    s3_nxt.zy    = s2_r.zy;
    s3_nxt.pt_in = s2_r.pt_in;
  end

  // Output stage: combine
  assign out_hit_nxt = s3_r.pt_in ||
                       (s3_r.okx && s3_r.oky &&
                        (s3_r.zx || s3_r.zy || ((s3_r.pa <= s3_r.pb) && (s3_r.pc <= s3_r.pd))));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s1_rdy)  s1_vld_r  <= in_ch.valid;
      if (s2_rdy)  s2_vld_r  <= s1_vld_r;
      if (s3_rdy)  s3_vld_r  <= s2_vld_r;
      if (out_rdy) out_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_ch.valid) s1_r      <= s1_nxt;
    if (s2_rdy && s1_vld_r)    s2_r      <= s2_nxt;
    if (s3_rdy && s2_vld_r)    s3_r      <= s3_nxt;
    if (out_rdy && s3_vld_r)   out_hit_r <= out_hit_nxt;
  end

  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ch.ready)
    else $error("request refused while the output register is empty");

  a_s1_advances: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && s2_rdy |=> s2_vld_r)
    else $error("stage one request lost on advance");

  a_s3_advances: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r && out_rdy |=> out_vld_r)
    else $error("stage three request lost on advance");

  a_point_inside: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r && s2_r.zx && s2_r.zy && s2_r.par_x && s2_r.par_y |-> s2_r.pt_in)
    else $error("degenerate segment in range but not flagged inside");

  a_denominator: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r && !s2_r.zx && !s2_r.zy |-> (s2_r.ax != '0) && (s2_r.ay != '0))
    else $error("zero denominator on a moving axis");

endmodule

`default_nettype wire

[tb/srct_hit_checker.sv]
// Checker for the segment / rectangle contact test: predicts each hit bit and compares it.
`timescale 1ns / 1ps

module srct_hit_checker (
  input  logic clk,
  input  logic rst_n,
  srct_req_if  req,
  srct_res_if  res,
  output int   fail_count,
  output int   outstanding
);
  import srct_pkg::*;

  typedef struct {
    int seq;
    bit hit;
  } hit_expect_t;

  hit_expect_t hit_expected_q[$];
  int          req_seq;

  function automatic bit point_in_box(longint px, longint py, longint lo_x, longint hi_x,
                                      longint lo_y, longint hi_y);
    return px >= lo_x && px <= hi_x && py >= lo_y && py <= hi_y;
  endfunction

  function automatic bit segment_touches_rect(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                                              coord_t rl, coord_t rr, coord_t rb, coord_t rt);
    longint x0, y0, x1, y1, lo_x, hi_x, lo_y, hi_y;
    longint p, q, n, d;
    longint ent_n, ent_d, ext_n, ext_d;
    longint pv[4];
    longint qv[4];
    x0 = sx; y0 = sy; x1 = ex; y1 = ey;
    lo_x = rl; hi_x = rr; lo_y = rb; hi_y = rt;
    if (point_in_box(x0, y0, lo_x, hi_x, lo_y, hi_y) ||
        point_in_box(x1, y1, lo_x, hi_x, lo_y, hi_y))
      return 1'b1;
    pv[0] = x0 - x1; qv[0] = x0 - lo_x;
    pv[1] = x1 - x0; qv[1] = hi_x - x0;
    pv[2] = y0 - y1; qv[2] = y0 - lo_y;
    pv[3] = y1 - y0; qv[3] = hi_y - y0;
    ent_n = 0; ent_d = 1;
    ext_n = 1; ext_d = 1;
    for (int i = 0; i < 4; i++) begin
      p = pv[i];
      q = qv[i];
      if (p == 0) begin
        if (q < 0)
          return 1'b0;
        continue;
      end
      n = (p < 0) ? -q : q;
      d = (p < 0) ? -p : p;
      // ratios compared by cross-multiplication; all products stay well inside 64 bits
      if (p < 0) begin
        if (n * ext_d > ext_n * d)
          return 1'b0;
        if (n * ent_d > ent_n * d) begin
          ent_n = n;
          ent_d = d;
        end
      end else begin
        if (n * ent_d < ent_n * d)
          return 1'b0;
        if (n * ext_d < ext_n * d) begin
          ext_n = n;
          ext_d = d;
        end
      end
    end
    return ent_n * ext_d <= ext_n * ent_d;
  endfunction

  always @(posedge clk) begin
    hit_expect_t want;
    if (!rst_n) begin
      fail_count = 0;
      req_seq    = 0;
      hit_expected_q.delete();
      outstanding <= 0;
    end else begin
      // check the result before logging a new request, so one cannot match itself
      if (res.valid && res.ready) begin
        if (hit_expected_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: hit=%0b with no request outstanding", res.hit);
          fail_count++;
        end else begin
          want = hit_expected_q.pop_front();
          if (res.hit !== want.hit) begin
            if (fail_count < 10)
              $display("hit mismatch on request %0d: expected %0b, got %0b",
                       want.seq, want.hit, res.hit);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        want.seq = req_seq;
        want.hit = segment_touches_rect(req.start_x, req.start_y, req.end_x, req.end_y,
                                        req.rect_left, req.rect_right,
                                        req.rect_bottom, req.rect_top);
        hit_expected_q.push_back(want);
        req_seq++;
      end
      outstanding <= hit_expected_q.size();
    end
  end

endmodule

[tb/tb_segment_rect_clip_test.sv]
// Testbench top for the segment / rectangle contact test: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_segment_rect_clip_test;
  import srct_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 1700;
  localparam int PHASE_ITEMS  = 170;

  logic clk;
  logic rst_n;
  bit   src_steady;
  bit   snk_steady;
  int   fail_count;
  int   outstanding;
  int   idle_cycles;
  int   stall_left;

  srct_req_if req_ch ();
  srct_res_if res_ch ();

  segment_rect_clip_test uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  srct_hit_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req_ch),
    .res         (res_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    else if (r < 98)
      return $urandom_range(4, 10);
    else
      return $urandom_range(20, 60);
  endfunction

  function automatic coord_t sat_coord(int v);
    if (v > 32767)
      return coord_t'(32767);
    if (v < -32768)
      return coord_t'(-32768);
    return coord_t'(v);
  endfunction

  function automatic coord_t any_coord();
    return coord_t'($urandom_range(0, 65535));
  endfunction

  // result side: random stalls, with calm stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!snk_steady && $urandom_range(0, 3) == 0) begin
      res_ch.ready <= 1'b0;
      stall_left   <= pick_gap();
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_segment_rect_clip_test: FAIL");
        $finish;
      end
    end
  end

  task automatic send_segment(input coord_t sx, input coord_t sy, input coord_t ex,
                              input coord_t ey, input coord_t rl, input coord_t rr,
                              input coord_t rb, input coord_t rt);
    int gap;
    req_ch.valid       <= 1'b1;
    req_ch.start_x     <= sx;
    req_ch.start_y     <= sy;
    req_ch.end_x       <= ex;
    req_ch.end_y       <= ey;
    req_ch.rect_left   <= rl;
    req_ch.rect_right  <= rr;
    req_ch.rect_bottom <= rb;
    req_ch.rect_top    <= rt;
    @(posedge clk);
    while (!req_ch.ready)
      @(posedge clk);
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_raw(input int sx, input int sy, input int ex, input int ey,
                          input int rl, input int rr, input int rb, input int rt);
    send_segment(coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey),
                 coord_t'(rl), coord_t'(rr), coord_t'(rb), coord_t'(rt));
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
  endtask

  task automatic send_random_segment();
    int kind, cx, cy, hw, hh, span, sx, sy, ex, ey, rl, rr, rb, rt;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      send_segment(any_coord(), any_coord(), any_coord(), any_coord(),
                   any_coord(), any_coord(), any_coord(), any_coord());
    end else begin
      // box somewhere in range, endpoints scattered around it
      span = ($urandom_range(0, 4) == 0) ? 16000 : 3000;
      cx = int'($urandom_range(0, 64000)) - 32000;
      cy = int'($urandom_range(0, 64000)) - 32000;
      hw = $urandom_range(0, span / 2);
      hh = $urandom_range(0, span / 2);
      rl = cx - hw; rr = cx + hw;
      rb = cy - hh; rt = cy + hh;
      sx = cx + int'($urandom_range(0, 4 * span)) - 2 * span;
      sy = cy + int'($urandom_range(0, 4 * span)) - 2 * span;
      ex = cx + int'($urandom_range(0, 4 * span)) - 2 * span;
      ey = cy + int'($urandom_range(0, 4 * span)) - 2 * span;
      if (kind < 40) begin
        if ($urandom_range(0, 1)) ey = sy;
        else ex = sx;
      end else if (kind < 47) begin
        ex = sx;
        ey = sy;
      end else if (kind < 53) begin
        if ($urandom_range(0, 1)) begin
          rl = cx + hw + 1; rr = cx - hw;
        end else begin
          rb = cy + hh + 1; rt = cy - hh;
        end
      end
      send_segment(sat_coord(sx), sat_coord(sy), sat_coord(ex), sat_coord(ey),
                   sat_coord(rl), sat_coord(rr), sat_coord(rb), sat_coord(rt));
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    src_steady         = 1'b0;
    snk_steady         = 1'b0;
    req_ch.valid       = 1'b0;
    req_ch.start_x     = '0;
    req_ch.start_y     = '0;
    req_ch.end_x       = '0;
    req_ch.end_y       = '0;
    req_ch.rect_left   = '0;
    req_ch.rect_right  = '0;
    req_ch.rect_bottom = '0;
    req_ch.rect_top    = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // point segments on and off a zero-size box
    send_raw(0, 0, 0, 0, 0, 0, 0, 0);
    send_raw(256, 0, 256, 0, 0, 0, 0, 0);
    send_raw(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    // endpoint on the closed boundary
    send_raw(-256, 0, -1024, 0, -256, 256, -256, 256);
    // crossing with both endpoints outside, both directions
    send_raw(-4096, 0, 4096, 0, -256, 256, -256, 256);
    send_raw(4096, 80, -4096, -80, -256, 256, -256, 256);
    // parallel to an edge: outside, and grazing it
    send_raw(-4096, 512, 4096, 512, -256, 256, -256, 256);
    send_raw(-4096, 256, 4096, 256, -256, 256, -256, 256);
    send_raw(-512, -4096, -512, 4096, -256, 256, -256, 256);
    // diagonal past a corner, then through it exactly
    send_raw(-768, 0, 0, 768, -256, 256, -256, 256);
    send_raw(-512, 0, 0, 512, -256, 256, -256, 256);
    // stops short of the box
    send_raw(-4096, 0, -512, 0, -256, 256, -256, 256);
    // near miss on a steep line
    send_raw(258, -4096, 256, 4096, -256, 256, -256, 256);
    // inverted boxes
    send_raw(-4096, 0, 4096, 0, 256, -256, -256, 256);
    send_raw(0, -4096, 0, 4096, -256, 256, 256, -256);
    // full-range coordinates
    send_raw(-32768, -32768, 32767, 32767, -1, 1, -1, 1);
    send_raw(-32768, 32767, 32767, -32768, 32000, 32767, -32768, -32000);
    send_raw(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767);
    send_raw(32767, -32768, -32768, 32767, -32768, 32767, -32768, 32767);
    send_raw(-32768, 32767, 32767, 32767, -32768, 32767, -32768, 32766);

    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        src_steady = ($urandom_range(0, 3) == 0);
        snk_steady = ($urandom_range(0, 3) == 0);
      end
      send_random_segment();
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("tb_segment_rect_clip_test: PASS");
    else
      $display("tb_segment_rect_clip_test: FAIL");
    $finish;
  end

endmodule
